@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyed top-k score table.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int SCORE_BITS  = 32;
  localparam int RANK_BITS   = 5;
  localparam int CFG_BITS    = 5;
  localparam int ACT_BITS    = 2;
  localparam int FIELD_KEY_BITS = 64;
  localparam logic [CFG_BITS-1:0] CFG_LIMIT_RESET = 5'd10;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_UPDATE = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic key_eq;   // stored key equals request key
    logic greater;  // request score strictly above stored score
  } cmp_res_t;

endpackage

@@ sv/kts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kts_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/kts_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_cmp
// Shared compare unit: key equality and signed score order.
// ----------------------------------------------------------------------------
module kts_cmp #(
  parameter int KEY_BITS = 64
) (
  input  logic [KEY_BITS-1:0]               req_key,
  input  logic signed [kts_pkg::SCORE_BITS-1:0] req_score,
  input  logic [KEY_BITS-1:0]               ent_key,
  input  logic signed [kts_pkg::SCORE_BITS-1:0] ent_score,
  output kts_pkg::cmp_res_t                 res
);
  import kts_pkg::*;

  always_comb begin
    res.key_eq  = (req_key == ent_key);
    res.greater = (req_score > ent_score);
  end

endmodule

@@ sv/keyed_top_k_score_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_top_k_score_table
// Ranked table of (key, score) pairs in descending score order, one RAM
// walked by a small sequencer through one shared compare unit.
// ----------------------------------------------------------------------------
// Each request is a scan of the live entries through the compare unit, a plan
//   step, then any slides of entries by one place (each a RAM read, then a write)
//   and, on a stored update, a final write of the new pair.
// busy stays high until the result, so one request is taken at a time; busy drops in the strobe cycle.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset (rst_n low, synchronous): table empty, limit 10, no request pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_top_k_score_table #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [kts_pkg::ACT_BITS-1:0]          in_action,
  input  logic [kts_pkg::FIELD_KEY_BITS-1:0]    in_player_key,
  input  logic signed [kts_pkg::SCORE_BITS-1:0] in_score,
  // result channel
  output logic                                  out_valid,
  output logic                                  out_in_table,
  output logic [kts_pkg::RANK_BITS-1:0]         out_new_position,
  output logic [kts_pkg::RANK_BITS-1:0]         out_old_position,
  // configuration: table limit
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [kts_pkg::CFG_BITS-1:0]          cfg_max_entries
);
  import kts_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;  // entry index
  localparam int CW = $clog2(MAX_ENTRIES + 1);                      // entry count
  localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;              // limit compare
  localparam int RW = (CW > RANK_BITS) ? CW : RANK_BITS;            // rank math
  localparam int DW = KEY_BITS + SCORE_BITS;                        // RAM word

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SCAN_RD  = 7'b0000010,
    ST_SCAN_CMP = 7'b0000100,
    ST_PLAN     = 7'b0001000,
    ST_MOVE_RD  = 7'b0010000,
    ST_MOVE_WR  = 7'b0100000,
    ST_PUT      = 7'b1000000
  } state_t;

  // Limit in use: register value saturated to the store depth.
  function automatic logic [CW-1:0] limit_of(input logic [CFG_BITS-1:0] v);
    logic [LW-1:0] ext;
    ext = LW'(v);
    if (ext > LW'(MAX_ENTRIES)) begin
      return CW'(MAX_ENTRIES);
    end
    return CW'(ext);
  endfunction

  state_t                 state_r, state_nxt;
  logic [CFG_BITS-1:0]    max_entries_r, max_entries_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  action_t                act_r, act_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic signed [SCORE_BITS-1:0] score_r, score_nxt;
  logic [CW-1:0]          j_r, j_nxt;          // scan pointer
  logic                   found_r, found_nxt;  // key seen in table
  logic [IW-1:0]          r_r, r_nxt;          // index of the old entry
  logic                   pfound_r, pfound_nxt;
  logic [CW-1:0]          p_r, p_nxt;          // insert slot, after removal
  logic [IW-1:0]          dst_r, dst_nxt;      // move destination
  logic [IW-1:0]          end_r, end_nxt;      // last move destination
  logic                   down_r, down_nxt;    // 1: slide toward head
  logic                   put_r, put_nxt;      // write the new pair at the end
  logic [IW-1:0]          ins_r, ins_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_in_table_r, out_in_table_nxt;
  logic [RANK_BITS-1:0]   out_new_r, out_new_nxt;
  logic [RANK_BITS-1:0]   out_old_r, out_old_nxt;

  logic [CW-1:0]          lim;
  logic                   accept;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [DW-1:0]          ram_wdata, ram_rdata;
  cmp_res_t               cmp;

  // plan-phase helpers
  logic [CW-1:0]          cnt_rm;   // count after removing the old entry
  logic [CW-1:0]          ins_pos;  // final insert slot
  logic [CW-1:0]          n_top;    // highest index after a fresh insert
  logic [RW-1:0]          old_rank, new_rank;

  assign lim       = limit_of(max_entries_r);
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // Entry store: {key, score} per rank slot.
  kts_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // One compare unit serves every scanned entry.
  kts_cmp #(
    .KEY_BITS(KEY_BITS)
  ) u_cmp (
    .req_key  (key_r),
    .req_score(score_r),
    .ent_key  (ram_rdata[DW-1:SCORE_BITS]),
    .ent_score(ram_rdata[SCORE_BITS-1:0]),
    .res      (cmp)
  );

  assign cnt_rm   = count_r - CW'(found_r);
  assign ins_pos  = pfound_r ? p_r : cnt_rm;
  assign n_top    = (count_r >= lim) ? (lim - CW'(1)) : count_r;
  assign old_rank = found_r ? (RW'(r_r) + RW'(1)) : '0;
  assign new_rank = RW'(ins_pos) + RW'(1);

  // RAM addressing: scan and move reads, move and put writes.
  always_comb begin
    ram_raddr = IW'(j_r);
    if (state_r == ST_MOVE_RD) begin
      ram_raddr = down_r ? (dst_r + IW'(1)) : (dst_r - IW'(1));
    end
    ram_we    = (state_r == ST_MOVE_WR) || (state_r == ST_PUT);
    ram_waddr = (state_r == ST_PUT) ? ins_r : dst_r;
    ram_wdata = (state_r == ST_PUT) ? {key_r, score_r} : ram_rdata;
  end

  always_comb begin
    state_nxt        = state_r;
    max_entries_nxt  = max_entries_r;
    count_nxt        = count_r;
    act_nxt          = act_r;
    key_nxt          = key_r;
    score_nxt        = score_r;
    j_nxt            = j_r;
    found_nxt        = found_r;
    r_nxt            = r_r;
    pfound_nxt       = pfound_r;
    p_nxt            = p_r;
    dst_nxt          = dst_r;
    end_nxt          = end_r;
    down_nxt         = down_r;
    put_nxt          = put_r;
    ins_nxt          = ins_r;
    out_valid_nxt    = 1'b0;
    out_in_table_nxt = out_in_table_r;
    out_new_nxt      = out_new_r;
    out_old_nxt      = out_old_r;

    // Limit write trims the tail right away.
    if (cfg_valid && cfg_ready) begin
      max_entries_nxt = cfg_max_entries;
      if (count_r > limit_of(cfg_max_entries)) begin
        count_nxt = limit_of(cfg_max_entries);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt    = action_t'(in_action);
          key_nxt    = in_player_key[KEY_BITS-1:0];
          score_nxt  = in_score;
          j_nxt      = '0;
          found_nxt  = 1'b0;
          pfound_nxt = 1'b0;
          // count after any limit write on the same edge
          state_nxt  = (count_nxt == '0) ? ST_PLAN : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        // Skip the matching entry; slot index counts only the others.
        if (cmp.key_eq) begin
          found_nxt = 1'b1;
          r_nxt     = IW'(j_r);
        end else if (!pfound_r && cmp.greater) begin
          pfound_nxt = 1'b1;
          p_nxt      = j_r - CW'(found_r);
        end
        j_nxt     = j_r + CW'(1);
        state_nxt = ((j_r + CW'(1)) == count_r) ? ST_PLAN : ST_SCAN_RD;
      end
      ST_PLAN: begin
        put_nxt          = 1'b0;
        ins_nxt          = IW'(ins_pos);
        out_old_nxt      = old_rank[RANK_BITS-1:0];
        out_new_nxt      = '0;
        out_in_table_nxt = 1'b0;
        state_nxt        = ST_IDLE;
        out_valid_nxt    = 1'b1;
        case (act_r)
          ACT_UPDATE: begin
            if (ins_pos < lim) begin
              out_new_nxt      = new_rank[RANK_BITS-1:0];
              out_in_table_nxt = 1'b1;
              put_nxt          = 1'b1;
              if (found_r && (CW'(r_r) < ins_pos)) begin
                // old entry above the slot: close the gap toward the head
                down_nxt = 1'b1;
                dst_nxt  = r_r;
                end_nxt  = IW'(ins_pos - CW'(1));
              end else if (found_r) begin
                // old entry at or below the slot: open a gap toward the tail
                down_nxt = 1'b0;
                dst_nxt  = r_r;
                end_nxt  = IW'(ins_pos + CW'(1));
              end else begin
                down_nxt  = 1'b0;
                dst_nxt   = IW'(n_top);
                end_nxt   = IW'(ins_pos + CW'(1));
                count_nxt = n_top + CW'(1);
              end
              if ((found_r && (CW'(r_r) == ins_pos)) ||
                  (!found_r && (n_top == ins_pos))) begin
                state_nxt     = ST_PUT;
                out_valid_nxt = 1'b0;
              end else begin
                state_nxt     = ST_MOVE_RD;
                out_valid_nxt = 1'b0;
              end
            end else if (found_r) begin
              // pair falls off the end: only remove the old entry
              down_nxt  = 1'b1;
              dst_nxt   = r_r;
              end_nxt   = IW'(count_r - CW'(2));
              count_nxt = count_r - CW'(1);
              if (CW'(r_r) != (count_r - CW'(1))) begin
                state_nxt     = ST_MOVE_RD;
                out_valid_nxt = 1'b0;
              end
            end
          end
          ACT_LOOKUP: begin
            out_new_nxt      = old_rank[RANK_BITS-1:0];
            out_in_table_nxt = found_r;
          end
          ACT_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            out_old_nxt = '0;
          end
        endcase
      end
      ST_MOVE_RD: begin
        state_nxt = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        if (dst_r == end_r) begin
          if (put_r) begin
            state_nxt = ST_PUT;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end
        end else begin
          dst_nxt   = down_r ? (dst_r + IW'(1)) : (dst_r - IW'(1));
          state_nxt = ST_MOVE_RD;
        end
      end
      ST_PUT: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      max_entries_r <= CFG_LIMIT_RESET;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      max_entries_r <= max_entries_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    act_r          <= act_nxt;
    key_r          <= key_nxt;
    score_r        <= score_nxt;
    j_r            <= j_nxt;
    found_r        <= found_nxt;
    r_r            <= r_nxt;
    pfound_r       <= pfound_nxt;
    p_r            <= p_nxt;
    dst_r          <= dst_nxt;
    end_r          <= end_nxt;
    down_r         <= down_nxt;
    put_r          <= put_nxt;
    ins_r          <= ins_nxt;
    out_in_table_r <= out_in_table_nxt;
    out_new_r      <= out_new_nxt;
    out_old_r      <= out_old_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_in_table     = out_in_table_r;
  assign out_new_position = out_new_r;
  assign out_old_position = out_old_r;

  // Table never holds more entries than the limit in use.
  `ASSERT_ALWAYS(a_count_in_limit, count_r <= lim, "entry count above limit")
  // An accepted request keeps the block busy on the next cycle.
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request not busy")
  // Result strobe only appears once the sequencer is back at rest.
  `ASSERT_ALWAYS(a_strobe_idle, !(out_valid && busy), "result strobe while busy")

endmodule

@@ dv/keyed_top_k_score_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_top_k_score_table_tb
// Self-checking bench for the ranked score table. A clocked driver feeds
// requests from a queue; a clocked monitor mirrors every accepted request and
// limit write into its own copy of the table and checks each result strobe
// against the oldest predicted ranks. Directed cases come first, then random
// phases under different table limits, with random sender gaps in all but one.
// ----------------------------------------------------------------------------
module keyed_top_k_score_table_tb;
  import kts_pkg::*;

  localparam int TBL_DEPTH = 16;   // matches the block's MAX_ENTRIES default
  localparam int POOL_SIZE = 22;   // more keys than slots, so the tail overflows
  localparam int DRAIN_CYCLES = 100;

  localparam logic [63:0] KEY_A = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] KEY_B = 64'hfedc_ba98_7654_3210;
  localparam logic [63:0] KEY_C = 64'h8000_0000_0000_0001;
  localparam logic [63:0] KEY_D = 64'h5555_aaaa_5555_aaaa;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

  typedef struct packed {
    action_t            act;
    logic [63:0]        key;
    logic signed [31:0] score;
  } score_req_t;

  typedef struct packed {
    logic       in_table;
    logic [4:0] new_pos;
    logic [4:0] old_pos;
  } rank_res_t;

  // DUT ports; every input starts at a known value
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_action = ACT_NONE;
  logic [63:0]         in_player_key = '0;
  logic signed [31:0]  in_score = '0;
  logic                out_valid;
  logic                out_in_table;
  logic [4:0]          out_new_position;
  logic [4:0]          out_old_position;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [4:0]          cfg_max_entries = CFG_LIMIT_RESET;

  score_req_t req_queue[$];     // requests not yet handed to the driver
  rank_res_t  rank_expect[$];   // predicted results, oldest first
  int         mismatch_count = 0;
  int         gap_pct = 10;     // sender idle chance, percent

  // Mirror of the table
  logic [63:0]        tbl_key   [TBL_DEPTH];
  logic signed [31:0] tbl_score [TBL_DEPTH];
  int                 tbl_count;
  logic [4:0]         tbl_limit;

  logic [63:0] key_pool [POOL_SIZE];

  keyed_top_k_score_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_player_key    (in_player_key),
    .in_score         (in_score),
    .out_valid        (out_valid),
    .out_in_table     (out_in_table),
    .out_new_position (out_new_position),
    .out_old_position (out_old_position),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_entries  (cfg_max_entries)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Table mirror
  // --------------------------------------------------------------------------

  // 1-based rank of a key among the live entries, 0 when absent
  function automatic int rank_of(input logic [63:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == key) return i + 1;
    end
    return 0;
  endfunction

  // Limit in force: register value, saturated to the store depth
  function automatic int limit_in_force();
    return (tbl_limit > TBL_DEPTH) ? TBL_DEPTH : int'(tbl_limit);
  endfunction

  // A limit write trims the tail at once
  task automatic rank_table_set_limit(input logic [4:0] value);
    tbl_limit = value;
    if (tbl_count > limit_in_force()) tbl_count = limit_in_force();
  endtask

  task automatic rank_table_apply(input score_req_t r, output rank_res_t res);
    int   old_rank;
    int   new_rank;
    int   lim;
    int   slot;
    int   last;
    logic present;
    old_rank = rank_of(r.key);
    new_rank = 0;
    present  = 1'b0;
    case (r.act)
      ACT_UPDATE: begin
        lim = limit_in_force();
        // drop the old entry of this key first
        if (old_rank != 0) begin
          for (int i = old_rank - 1; i < tbl_count - 1; i++) begin
            tbl_key[i]   = tbl_key[i+1];
            tbl_score[i] = tbl_score[i+1];
          end
          tbl_count--;
        end
        // first slot with a strictly lower score; ties stay ahead
        slot = tbl_count;
        for (int i = tbl_count - 1; i >= 0; i--) begin
          if ($signed(r.score) > $signed(tbl_score[i])) slot = i;
        end
        if (slot < lim) begin
          last = (tbl_count >= lim) ? lim - 1 : tbl_count;
          for (int i = last; i > slot; i--) begin
            tbl_key[i]   = tbl_key[i-1];
            tbl_score[i] = tbl_score[i-1];
          end
          tbl_key[slot]   = r.key;
          tbl_score[slot] = r.score;
          tbl_count = last + 1;
          new_rank  = slot + 1;
          present   = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        new_rank = old_rank;
        present  = (old_rank != 0);
      end
      ACT_CLEAR: begin
        tbl_count = 0;
      end
      default: begin
        // unused code: nothing changes, all result fields zero
        old_rank = 0;
      end
    endcase
    res.in_table = present;
    res.new_pos  = new_rank[4:0];
    res.old_pos  = old_rank[4:0];
  endtask

  // --------------------------------------------------------------------------
  // Driver: one request per start/!busy handshake. A new request is picked
  // only when the slot frees up, so start is assigned once per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    score_req_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        r = req_queue.pop_front();
        start         <= 1'b1;
        in_action     <= r.act;
        in_player_key <= r.key;
        in_score      <= r.score;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: mirrors limit writes and accepted requests, checks each strobe.
  // Sampled at the edge, so all values are the ones from before it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    score_req_t r;
    rank_res_t  want;
    if (!rst_n) begin
      tbl_count = 0;
      tbl_limit = CFG_LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) rank_table_set_limit(cfg_max_entries);
      if (start && !busy) begin
        r.act   = action_t'(in_action);
        r.key   = in_player_key;
        r.score = in_score;
        rank_table_apply(r, want);
        rank_expect.push_back(want);
      end
      if (out_valid) begin
        if (rank_expect.size() == 0) begin
          $error("result with nothing outstanding: in_table %0d new %0d old %0d",
                 out_in_table, out_new_position, out_old_position);
          mismatch_count++;
        end else begin
          want = rank_expect.pop_front();
          if (out_in_table !== want.in_table) begin
            $error("in_table: expected %0d, got %0d", want.in_table, out_in_table);
            mismatch_count++;
          end
          if (out_new_position !== want.new_pos) begin
            $error("new_position: expected %0d, got %0d", want.new_pos, out_new_position);
            mismatch_count++;
          end
          if (out_old_position !== want.old_pos) begin
            $error("old_position: expected %0d, got %0d", want.old_pos, out_old_position);
            mismatch_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_req(input action_t act, input logic [63:0] key,
                          input logic signed [31:0] score);
    score_req_t r;
    r.act   = act;
    r.key   = key;
    r.score = score;
    req_queue.push_back(r);
  endtask

  // Idle means: nothing queued, nothing on the wire, nothing outstanding.
  // Checked at the falling edge, where every clocked update has settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (req_queue.size() != 0 || start || busy || rank_expect.size() != 0);
  endtask

  // Limit write, only ever issued while the table is idle
  task automatic write_limit(input logic [4:0] value);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_max_entries <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Fresh key set per phase; zero and all-ones always in it
  task automatic refresh_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
  endtask

  task automatic push_random(input int count);
    action_t            act;
    logic [63:0]        key;
    logic signed [31:0] score;
    int                 sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 62)      act = ACT_UPDATE;
      else if (sel < 95) act = ACT_LOOKUP;
      else if (sel < 97) act = ACT_CLEAR;
      else               act = ACT_NONE;
      // mostly pool keys so updates and lookups hit live entries
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else                         key = {$urandom, $urandom};
      // narrow band gives plenty of ties; the rest spans the full range
      sel = $urandom_range(99);
      if (sel < 45)      score = int'($urandom_range(8)) - 4;
      else if (sel < 55) score = $urandom_range(1) ? SCORE_MAX : SCORE_MIN;
      else               score = $urandom;
      push_req(act, key, score);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [4:0] phase_limit [9];
    int         phase_items [9];
    phase_limit = '{5'd31, 5'd16, 5'd1, 5'd3, 5'd10, 5'd0, 5'd2, 5'd16, 5'd31};
    phase_items = '{200, 200, 200, 200, 200, 30, 200, 200, 200};
    phase_limit[4] = 5'($urandom_range(16, 1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Reset limit of ten: empty lookup, score extremes, ties, moves up and
    // down, both key extremes, unused action code, clear.
    push_req(ACT_LOOKUP, KEY_A, 0);
    push_req(ACT_UPDATE, KEY_A, SCORE_MAX);
    push_req(ACT_UPDATE, KEY_B, SCORE_MIN);
    push_req(ACT_UPDATE, KEY_C, 0);
    push_req(ACT_UPDATE, KEY_D, 0);
    push_req(ACT_UPDATE, KEY_B, 100);
    push_req(ACT_UPDATE, KEY_A, -5);
    push_req(ACT_LOOKUP, KEY_B, 0);
    push_req(ACT_NONE,   KEY_C, 7);
    push_req(ACT_UPDATE, '1, -1);
    push_req(ACT_UPDATE, '0, -1);
    push_req(ACT_CLEAR,  KEY_C, 0);
    push_req(ACT_LOOKUP, KEY_C, 0);
    wait_idle();

    // Limit two: third equal score falls off the end, a higher one pushes
    // the tail out.
    write_limit(5'd2);
    push_req(ACT_UPDATE, KEY_A, 5);
    push_req(ACT_UPDATE, KEY_B, 5);
    push_req(ACT_UPDATE, KEY_C, 5);
    push_req(ACT_UPDATE, KEY_C, 6);
    push_req(ACT_LOOKUP, KEY_B, 0);
    wait_idle();

    // Limit zero: the write empties the table, updates store nothing
    write_limit(5'd0);
    push_req(ACT_LOOKUP, KEY_C, 0);
    push_req(ACT_UPDATE, KEY_C, 9);
    push_req(ACT_LOOKUP, KEY_C, 0);
    wait_idle();

    // Random phases. Most limit writes land on a full-ish table, so they also
    // check the trim. Every phase boundary holds the sender until the table
    // has answered everything.
    for (int ph = 0; ph < 9; ph++) begin
      refresh_pool();
      gap_pct = (ph == 2) ? 0 : 10;   // one phase with no sender gaps
      write_limit(phase_limit[ph]);
      push_random(phase_items[ph]);
      wait_idle();
    end

    // Anything that shows up now is a stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("keyed_top_k_score_table_tb: done, clean");
    end else begin
      $display("keyed_top_k_score_table_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: a hung run ends with the error report
  initial begin
    #2_000_000;
    $display("keyed_top_k_score_table_tb: done, errors");
    $finish;
  end

endmodule

@@ keyed_top_k_score_table.f @@
+incdir+sv
sv/kts_pkg.sv
sv/kts_ram.sv
sv/kts_cmp.sv
sv/keyed_top_k_score_table.sv
dv/keyed_top_k_score_table_tb.sv
